@@ rtl/bfst_pkg.sv @@
// package: shared types, constants and codes of the flow statistics table
package bfst_pkg;

	localparam int FLOW_ENTRIES_DEF = 1024;
	localparam logic [15:0] WKP_LIMIT_RESET = 16'd1024;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_WKP_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		STATUS_IGNORED = 2'd0,
		STATUS_UPDATED = 2'd1,
		STATUS_INSERTED = 2'd2,
		STATUS_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		METHOD_SYN = 2'd0,
		METHOD_WELL_KNOWN = 2'd1,
		METHOD_LOWER_PORT = 2'd2
	} method_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOOK,
		ST_CMP,
		ST_INS,
		ST_HIT_RD,
		ST_HIT_UPD,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic        header_ok;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  protocol;
		logic        tcp_syn;
		logic        tcp_ack;
		logic [15:0] total_length;
		logic [47:0] now;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  entry_index;
		logic [31:0] fwd_packet_count;
		logic [31:0] rev_packet_count;
		logic [47:0] fwd_byte_count;
		logic [47:0] rev_byte_count;
		logic [47:0] first_seen;
		logic [47:0] last_seen;
		logic [31:0] server_address;
		logic [1:0]  server_method;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] lo_ip;
		logic [31:0] hi_ip;
		logic [15:0] lo_port;
		logic [15:0] hi_port;
		logic [7:0]  proto;
	} flow_key_t;

	typedef struct packed {
		logic [31:0] fwd_packets;
		logic [31:0] rev_packets;
		logic [47:0] fwd_bytes;
		logic [47:0] rev_bytes;
		logic [47:0] start_time;
		logic [47:0] alive_time;
		logic [31:0] srv_addr;
		logic [1:0]  method;
	} flow_rec_t;

	// controller to datapath
	typedef struct packed {
		logic    accept;
		logic    key_rd;
		logic    scan_next;
		logic    rec_rd;
		logic    commit;
		logic    insert;
		logic    out_load;
		status_t out_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic relevant;
		logic empty;
		logic match;
		logic scan_last;
		logic full;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/bfst_ram.sv @@
// generic simple dual-port ram with registered read
module bfst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bfst_ctrl.sv @@
// controller: sequences lookup, insert, update and result hand-off
module bfst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfst_pkg::dp_sts_t sts,
	output bfst_pkg::dp_cmd_t cmd
);
	import bfst_pkg::*;

	ctrl_state_t state_q, state_d;
	status_t     code_q, code_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= STATUS_IGNORED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.out_status = code_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.relevant) begin
					code_d  = STATUS_IGNORED;
					state_d = ST_FIN;
				end else if (sts.empty) begin
					state_d = ST_INS;
				end else begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.key_rd = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				if (sts.match) begin
					state_d = ST_HIT_RD;
				end else if (!sts.scan_last) begin
					cmd.scan_next = 1'b1;
					state_d       = ST_LOOK;
				end else if (sts.full) begin
					code_d  = STATUS_FULL;
					state_d = ST_FIN;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				cmd.commit = 1'b1;
				cmd.insert = 1'b1;
				code_d     = STATUS_INSERTED;
				state_d    = ST_FIN;
			end
			ST_HIT_RD: begin
				cmd.rec_rd = 1'b1;
				state_d    = ST_HIT_UPD;
			end
			ST_HIT_UPD: begin
				cmd.commit = 1'b1;
				code_d     = STATUS_UPDATED;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// checks
	a_load_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state_q == ST_FIN)
		else $error("result loaded outside finish state");
	a_commit_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.relevant)
		else $error("table written for an ignored packet");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_CHECK)
		else $error("accepted beat not checked");

endmodule

@@ rtl/bfst_dp.sv @@
// datapath: key forming, table memories, scan, counter update, result register
module bfst_dp #(
	parameter int FLOW_ENTRIES = bfst_pkg::FLOW_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        wkp_limit,
	input  bfst_pkg::in_beat_t in_data,
	input  bfst_pkg::dp_cmd_t  cmd,
	output bfst_pkg::dp_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output bfst_pkg::out_beat_t out_data
);
	import bfst_pkg::*;

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(FLOW_ENTRIES);

	in_beat_t   in_q;
	flow_key_t  key_q, key_d;
	logic       relevant_q;
	logic [IDX_W-1:0] scan_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] slot_q, waddr;
	flow_rec_t  res_q, upd, base, ins_rec, rec_rdata;
	flow_key_t  key_rdata;
	logic       out_valid_q;
	out_beat_t  out_q, out_d;
	logic       is_fwd;
	logic [31:0] guess_ip;
	method_t    guess_m;
	logic [48:0] fwd_sum, rev_sum;

	// direction-free key
	always_comb begin
		if (in_data.src_ip < in_data.dst_ip) begin
			key_d.lo_ip   = in_data.src_ip;
			key_d.hi_ip   = in_data.dst_ip;
			key_d.lo_port = in_data.sport;
			key_d.hi_port = in_data.dport;
		end else begin
			key_d.lo_ip   = in_data.dst_ip;
			key_d.hi_ip   = in_data.src_ip;
			key_d.lo_port = in_data.dport;
			key_d.hi_port = in_data.sport;
		end
		key_d.proto = in_data.protocol;
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q       <= in_data;
			key_q      <= key_d;
			relevant_q <= in_data.header_ok &&
				(in_data.protocol == PROTO_TCP || in_data.protocol == PROTO_UDP);
		end
	end

	// scan pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.accept) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.commit && cmd.insert) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign waddr = cmd.insert ? fill_q[IDX_W-1:0] : scan_q;

	bfst_ram #(.WIDTH($bits(flow_key_t)), .DEPTH(FLOW_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (cmd.commit && cmd.insert),
		.waddr (waddr),
		.wdata (key_q),
		.re    (cmd.key_rd),
		.raddr (scan_q),
		.rdata (key_rdata)
	);

	bfst_ram #(.WIDTH($bits(flow_rec_t)), .DEPTH(FLOW_ENTRIES)) u_rec_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (waddr),
		.wdata (upd),
		.re    (cmd.rec_rd),
		.raddr (scan_q),
		.rdata (rec_rdata)
	);

	// server guess for a new flow
	always_comb begin
		if (in_q.protocol == PROTO_TCP && in_q.tcp_syn) begin
			guess_m  = METHOD_SYN;
			guess_ip = in_q.tcp_ack ? in_q.src_ip : in_q.dst_ip;
		end else if (in_q.dport < wkp_limit) begin
			guess_m  = METHOD_WELL_KNOWN;
			guess_ip = in_q.dst_ip;
		end else if (in_q.sport < wkp_limit) begin
			guess_m  = METHOD_WELL_KNOWN;
			guess_ip = in_q.src_ip;
		end else begin
			guess_m  = METHOD_LOWER_PORT;
			guess_ip = (in_q.dport <= in_q.sport) ? in_q.dst_ip : in_q.src_ip;
		end
	end

	// fresh entry
	always_comb begin
		ins_rec            = '0;
		ins_rec.start_time = in_q.now;
		ins_rec.alive_time = in_q.now;
		ins_rec.srv_addr   = guess_ip;
		ins_rec.method     = guess_m;
	end

	assign base   = cmd.insert ? ins_rec : rec_rdata;
	assign is_fwd = (in_q.src_ip <= in_q.dst_ip);

	assign fwd_sum = {1'b0, base.fwd_bytes} + {33'd0, in_q.total_length};
	assign rev_sum = {1'b0, base.rev_bytes} + {33'd0, in_q.total_length};

	// saturating counter update
	always_comb begin
		upd            = base;
		upd.alive_time = in_q.now;
		if (is_fwd) begin
			if (base.fwd_packets != '1) begin
				upd.fwd_packets = base.fwd_packets + 1'b1;
			end
			upd.fwd_bytes = fwd_sum[48] ? '1 : fwd_sum[47:0];
		end else begin
			if (base.rev_packets != '1) begin
				upd.rev_packets = base.rev_packets + 1'b1;
			end
			upd.rev_bytes = rev_sum[48] ? '1 : rev_sum[47:0];
		end
	end

	// result of the touched entry
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q  <= upd;
			slot_q <= waddr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat, all zero apart from the status unless an entry was touched
	always_comb begin
		out_d        = '0;
		out_d.status = cmd.out_status;
		if (cmd.out_status == STATUS_UPDATED || cmd.out_status == STATUS_INSERTED) begin
			out_d.entry_index      = 10'(slot_q);
			out_d.fwd_packet_count = res_q.fwd_packets;
			out_d.rev_packet_count = res_q.rev_packets;
			out_d.fwd_byte_count   = res_q.fwd_bytes;
			out_d.rev_byte_count   = res_q.rev_bytes;
			out_d.first_seen       = res_q.start_time;
			out_d.last_seen        = res_q.alive_time;
			out_d.server_address   = res_q.srv_addr;
			out_d.server_method    = res_q.method;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	assign sts.relevant  = relevant_q;
	assign sts.empty     = (fill_q == '0);
	assign sts.match     = (key_rdata == key_q);
	assign sts.scan_last = ({1'b0, scan_q} + 1'b1 == fill_q);
	assign sts.full      = (fill_q == FILL_MAX);
	assign sts.out_free  = !out_valid_q || out_ready;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond table size");
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && cmd.insert |-> !sts.full)
		else $error("insert into a full table");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");
	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.key_rd |-> ({1'b0, scan_q} < fill_q))
		else $error("scan beyond filled slots");

endmodule

@@ rtl/bidirectional_flow_stats_table_unit.sv @@
// top level: flow statistics table with apb register port
// sequence: an ignored packet goes from check straight to finish; otherwise a key ram read
// then a compare per slot, k+1 slots for a hit in slot k and every filled slot for a miss,
// then insert, or record read and update; a held result stalls the finish state
// throughput: one packet in flight; next beat accepted the cycle after the result is registered
// reset: asynchronous active low; fill count cleared so the table is empty at once, limit 1024
module bidirectional_flow_stats_table_unit #(
	parameter int FLOW_ENTRIES = bfst_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bfst_pkg::in_beat_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bfst_pkg::out_beat_t          out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bfst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bfst_pkg::*;

	logic [15:0] wkp_limit_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wkp_limit_q <= WKP_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WKP_LIMIT) begin
			wkp_limit_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WKP_LIMIT) ? {16'd0, wkp_limit_q} : 32'd0;

	bfst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfst_dp #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wkp_limit (wkp_limit_q),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ dv/bidirectional_flow_stats_table_unit_tb.sv @@
// testbench: flow statistics table checked against a scoreboard of predicted flow records
`timescale 1ns / 1ps

module bidirectional_flow_stats_table_unit_tb;
	import bfst_pkg::*;

	localparam int ENTRIES = FLOW_ENTRIES_DEF;
	localparam int RANDOM_HEADERS = 1100;
	localparam int POOL_FLOWS = 32;

	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predicted table contents
	bit slot_used [ENTRIES];
	flow_key_t slot_key [ENTRIES];
	flow_rec_t slot_rec [ENTRIES];
	int used_slots;
	logic [15:0] port_limit;

	out_beat_t awaited_results[$];
	int mismatches;
	int results_seen;
	bit calm;
	int hold_off;
	logic [47:0] clock_now;
	in_beat_t flow_pool [POOL_FLOWS];

	bidirectional_flow_stats_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end

	// flow lookup, insert and counter update as the table does it
	function automatic out_beat_t predict_flow(in_beat_t b);
		out_beat_t r;
		flow_key_t k;
		int slot;
		int free_slot;
		bit hit;
		bit has_free;
		logic [48:0] sum;
		r = '0;
		if (!b.header_ok || (b.protocol != PROTO_TCP && b.protocol != PROTO_UDP))
			return r;
		if (b.src_ip < b.dst_ip)
			k = {b.src_ip, b.dst_ip, b.sport, b.dport, b.protocol};
		else
			k = {b.dst_ip, b.src_ip, b.dport, b.sport, b.protocol};
		hit = 0;
		has_free = 0;
		slot = 0;
		free_slot = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i]) begin
				if (!hit && slot_key[i] == k) begin
					hit = 1;
					slot = i;
				end
			end else if (!has_free) begin
				has_free = 1;
				free_slot = i;
			end
		end
		if (hit) begin
			r.status = STATUS_UPDATED;
		end else if (has_free) begin
			slot = free_slot;
			slot_used[slot] = 1;
			slot_key[slot] = k;
			used_slots++;
			slot_rec[slot] = '0;
			slot_rec[slot].start_time = b.now;
			// server guess: syn flags, then well-known port, then lower port
			if (b.protocol == PROTO_TCP && b.tcp_syn) begin
				slot_rec[slot].method = METHOD_SYN;
				slot_rec[slot].srv_addr = b.tcp_ack ? b.src_ip : b.dst_ip;
			end else if (b.dport < port_limit) begin
				slot_rec[slot].method = METHOD_WELL_KNOWN;
				slot_rec[slot].srv_addr = b.dst_ip;
			end else if (b.sport < port_limit) begin
				slot_rec[slot].method = METHOD_WELL_KNOWN;
				slot_rec[slot].srv_addr = b.src_ip;
			end else begin
				slot_rec[slot].method = METHOD_LOWER_PORT;
				slot_rec[slot].srv_addr = (b.dport <= b.sport) ? b.dst_ip : b.src_ip;
			end
			r.status = STATUS_INSERTED;
		end else begin
			r.status = STATUS_FULL;
			return r;
		end
		// saturating counters in the packet's direction
		if (b.src_ip == k.lo_ip) begin
			if (slot_rec[slot].fwd_packets != '1)
				slot_rec[slot].fwd_packets++;
			sum = {1'b0, slot_rec[slot].fwd_bytes} + b.total_length;
			slot_rec[slot].fwd_bytes = sum[48] ? '1 : sum[47:0];
		end else begin
			if (slot_rec[slot].rev_packets != '1)
				slot_rec[slot].rev_packets++;
			sum = {1'b0, slot_rec[slot].rev_bytes} + b.total_length;
			slot_rec[slot].rev_bytes = sum[48] ? '1 : sum[47:0];
		end
		slot_rec[slot].alive_time = b.now;
		r.entry_index = slot[9:0];
		r.fwd_packet_count = slot_rec[slot].fwd_packets;
		r.rev_packet_count = slot_rec[slot].rev_packets;
		r.fwd_byte_count = slot_rec[slot].fwd_bytes;
		r.rev_byte_count = slot_rec[slot].rev_bytes;
		r.first_seen = slot_rec[slot].start_time;
		r.last_seen = slot_rec[slot].alive_time;
		r.server_address = slot_rec[slot].srv_addr;
		r.server_method = slot_rec[slot].method;
		return r;
	endfunction

	function automatic in_beat_t make_header(bit ok, logic [31:0] sip, logic [31:0] dip,
			logic [15:0] sp, logic [15:0] dp, logic [7:0] proto, bit syn, bit ack,
			logic [15:0] len, logic [47:0] ts);
		in_beat_t b;
		b = {ok, sip, dip, sp, dp, proto, syn, ack, len, ts};
		return b;
	endfunction

	// one header beat; valid is only lowered for a deliberate gap
	task automatic send_header(in_beat_t b, bit typed, out_beat_t result);
		out_beat_t predicted;
		if (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		predicted = predict_flow(b);
		awaited_results.push_back(typed ? result : predicted);
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_port_limit(logic [15:0] value);
		logic [31:0] readback;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= PADDR_W'(REG_WKP_LIMIT) << 2;
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		port_limit = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[15:0] !== value) begin
			$error("well_known_port_limit: expected %0h actual %0h", value, readback[15:0]);
			mismatches++;
		end
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(3))
			0: return 16'($urandom_range(1023));
			1: return 16'($urandom);
			2: return 16'($urandom_range(65535, 65500));
			default: return 16'($urandom_range(2000));
		endcase
	endfunction

	function automatic logic [47:0] next_time();
		clock_now = 48'(clock_now + 48'($urandom_range(1000)));
		if ($urandom_range(49) == 0)
			clock_now = 48'({$urandom, $urandom});
		return clock_now;
	endfunction

	// random header: mostly known flows, some fresh flows, some noise
	function automatic in_beat_t random_header();
		in_beat_t b;
		int pick;
		pick = $urandom_range(99);
		b.header_ok = 1'b1;
		b.src_ip = $urandom;
		b.dst_ip = $urandom;
		b.sport = 16'($urandom);
		b.dport = 16'($urandom);
		b.protocol = 8'($urandom);
		b.tcp_syn = 1'($urandom);
		b.tcp_ack = 1'($urandom);
		b.total_length = 16'($urandom);
		b.now = next_time();
		if (pick < 80) begin
			in_beat_t f;
			f = flow_pool[$urandom_range(POOL_FLOWS - 1)];
			if ($urandom_range(1)) begin
				b.src_ip = f.src_ip; b.dst_ip = f.dst_ip;
				b.sport = f.sport; b.dport = f.dport;
			end else begin
				b.src_ip = f.dst_ip; b.dst_ip = f.src_ip;
				b.sport = f.dport; b.dport = f.sport;
			end
			b.protocol = f.protocol;
		end else if (pick < 88) begin
			b.sport = pick_port();
			b.dport = pick_port();
			b.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		end else if (pick < 94) begin
			b.header_ok = 1'b0;
			if ($urandom_range(1))
				b.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		end else begin
			do b.protocol = 8'($urandom);
			while (b.protocol == PROTO_TCP || b.protocol == PROTO_UDP);
		end
		return b;
	endfunction

	function automatic bit is_relevant(in_beat_t b);
		return b.header_ok && (b.protocol == PROTO_TCP || b.protocol == PROTO_UDP);
	endfunction

	// result checker
	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
			end else begin
				e = awaited_results.pop_front();
				check_field("status", e.status, out_data.status);
				check_field("entry_index", e.entry_index, out_data.entry_index);
				check_field("fwd_packet_count", e.fwd_packet_count, out_data.fwd_packet_count);
				check_field("rev_packet_count", e.rev_packet_count, out_data.rev_packet_count);
				check_field("fwd_byte_count", e.fwd_byte_count, out_data.fwd_byte_count);
				check_field("rev_byte_count", e.rev_byte_count, out_data.rev_byte_count);
				check_field("first_seen", e.first_seen, out_data.first_seen);
				check_field("last_seen", e.last_seen, out_data.last_seen);
				check_field("server_address", e.server_address, out_data.server_address);
				check_field("server_method", e.server_method, out_data.server_method);
			end
		end
	end

	// receiver: random stalls, one long hold-off, calm stretches
	initial begin
		out_ready = 1'b0;
		hold_off = 0;
		forever begin
			@(posedge clk);
			if (results_seen == 600 && hold_off == 0)
				hold_off = 400;
			if (hold_off > 1) begin
				out_ready <= 1'b0;
				hold_off--;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 31;
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		out_beat_t zero_result;
		in_beat_t b;
		int relevant;
		logic [15:0] limits [4];

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		results_seen = 0;
		calm = 1'b0;
		used_slots = 0;
		port_limit = WKP_LIMIT_RESET;
		clock_now = 48'h1000;
		zero_result = '0;
		foreach (slot_used[i]) slot_used[i] = 0;
		foreach (flow_pool[i]) begin
			flow_pool[i] = '0;
			flow_pool[i].src_ip = $urandom;
			flow_pool[i].dst_ip = (i % 8 == 0) ? flow_pool[i].src_ip : $urandom;
			flow_pool[i].sport = pick_port();
			flow_pool[i].dport = pick_port();
			flow_pool[i].protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: ignored packets typed in, the rest predicted
		row.typed = 1;
		row.result = zero_result;
		row.beat = make_header(0, '1, '1, '1, '1, PROTO_TCP, 1, 1, '1, '1);
		rows.push_back(row);
		row.beat = make_header(1, 32'h1, 32'h2, 16'd80, 16'd80, 8'd1, 0, 0, 16'd60, 48'h10);
		rows.push_back(row);
		row.beat = make_header(1, 32'h1, 32'h2, 16'd80, 16'd80, 8'hFF, 0, 0, 16'd60, 48'h11);
		rows.push_back(row);
		row.beat = make_header(1, 32'h1, 32'h2, 16'd80, 16'd80, 8'd0, 0, 0, 16'd60, 48'h12);
		rows.push_back(row);
		row.typed = 0;
		// tcp syn from client, then syn-ack back: syn guess and reverse count
		row.beat = make_header(1, 32'h0A000001, 32'h0A000002, 16'd40000, 16'd443,
			PROTO_TCP, 1, 0, 16'd60, 48'h100);
		rows.push_back(row);
		row.beat = make_header(1, 32'h0A000002, 32'h0A000001, 16'd443, 16'd40000,
			PROTO_TCP, 1, 1, 16'd60, 48'h101);
		rows.push_back(row);
		// syn-ack seen first
		row.beat = make_header(1, 32'hC0A80005, 32'hC0A80001, 16'd5000, 16'd6000,
			PROTO_TCP, 1, 1, 16'd40, 48'h102);
		rows.push_back(row);
		// udp ignores flag bits
		row.beat = make_header(1, 32'h5, 32'h6, 16'd3000, 16'd53, PROTO_UDP, 1, 1,
			16'd100, 48'h103);
		rows.push_back(row);
		// well-known source port
		row.beat = make_header(1, 32'h7, 32'h8, 16'd22, 16'd50000, PROTO_TCP, 0, 1,
			16'd1500, 48'h104);
		rows.push_back(row);
		// lower port wins, and a tie picks the destination
		row.beat = make_header(1, 32'h9, 32'h3, 16'd9000, 16'd8000, PROTO_UDP, 0, 0,
			16'd1, 48'h105);
		rows.push_back(row);
		row.beat = make_header(1, 32'h9, 32'h4, 16'd9000, 16'd9000, PROTO_UDP, 0, 0,
			16'd1, 48'h106);
		rows.push_back(row);
		// equal addresses, both port orders
		row.beat = make_header(1, 32'h77, 32'h77, 16'd2000, 16'd3000, PROTO_UDP, 0, 0,
			16'd10, 48'h107);
		rows.push_back(row);
		row.beat = make_header(1, 32'h77, 32'h77, 16'd3000, 16'd2000, PROTO_UDP, 0, 0,
			16'd10, 48'h108);
		rows.push_back(row);
		// field extremes
		row.beat = make_header(1, '1, '0, '1, '1, PROTO_TCP, 0, 0, '1, '1);
		rows.push_back(row);
		row.beat = make_header(1, '0, '1, '0, '0, PROTO_TCP, 0, 0, '1, '0);
		rows.push_back(row);
		row.beat = make_header(1, '0, '0, '0, '0, PROTO_UDP, 0, 0, '0, '0);
		rows.push_back(row);
		row.beat = make_header(1, '1, '1, '1, '1, PROTO_UDP, 0, 0, '1, '1);
		rows.push_back(row);
		row.beat = make_header(1, 32'h0A000001, 32'h0A000002, 16'd40000, 16'd443,
			PROTO_TCP, 0, 1, 16'hFFFF, 48'h200);
		rows.push_back(row);
		foreach (rows[i])
			send_header(rows[i].beat, rows[i].typed, rows[i].result);

		// random phases over several limit settings
		limits[0] = 16'd0;
		limits[1] = 16'hFFFF;
		limits[2] = 16'($urandom);
		limits[3] = 16'($urandom_range(2000));
		relevant = 0;
		for (int p = 0; p < 4; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			write_port_limit(limits[p]);
			for (int n = 0; n < RANDOM_HEADERS / 4; ) begin
				b = random_header();
				send_header(b, 0, zero_result);
				if (is_relevant(b)) begin
					n++;
					relevant++;
				end
				calm = (relevant % 500) >= 400;
				// sender pause until the table has answered everything
				if (relevant == 1000 && is_relevant(b)) begin
					in_valid <= 1'b0;
					wait_drained();
				end
			end
		end

		// fill the table, then misses report full while hits still update
		calm = 1'b1;
		while (used_slots < ENTRIES) begin
			b = make_header(1, 32'hC6000000 | used_slots, 32'hC7000000 | used_slots,
				pick_port(), pick_port(), PROTO_UDP, 0, 0, 16'($urandom), next_time());
			send_header(b, 0, zero_result);
		end
		calm = 1'b0;
		row.result = zero_result;
		row.result.status = STATUS_FULL;
		for (int n = 0; n < 4; n++) begin
			b = make_header(1, 32'hD0000000 + n, 32'hD1000000, 16'd1, 16'd2, PROTO_TCP,
				1, 0, 16'd64, next_time());
			send_header(b, 1, row.result);
			b = flow_pool[n];
			b.header_ok = 1'b1;
			b.now = next_time();
			send_header(b, 0, zero_result);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ bidirectional_flow_stats_table_unit.f @@
rtl/bfst_pkg.sv
rtl/bfst_ram.sv
rtl/bfst_ctrl.sv
rtl/bfst_dp.sv
rtl/bidirectional_flow_stats_table_unit.sv
dv/bidirectional_flow_stats_table_unit_tb.sv
